// ===== hdl/nearest_fit_cell_allocator_assert.svh =====
// Assertion macros for the checker file of the allocator.
`ifndef NEAREST_FIT_CELL_ALLOCATOR_ASSERT_SVH
`define NEAREST_FIT_CELL_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFCA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NFCA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/nfca_pkg.sv =====
package nfca_pkg;

  localparam int NFCA_DEPTH   = 256;
  localparam int NFCA_MAX_RUN = 32;

  localparam int INDEX_W  = 8;
  localparam int RUN_W    = 6;
  localparam int STATUS_W = 2;
  localparam int LENGTH_W = 9;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_FREE_SKIP = 2'd2
  } status_t;

endpackage

// ===== hdl/nearest_fit_cell_allocator.sv =====
// Nearest-fit run allocator over a map of used cells.
// Input items arrive on the s_ channel: tuser carries the request kind and
// tdata the near or target cell and the run length. Each item yields exactly
// one result item on the m_ channel with the chosen base cell, a status code
// and the high-water length of the region after the request.
// A free request goes from acceptance straight to the result state.
// An allocation reads the map one bit per cycle from the top of the region
// down to cell 0 through the single read port of the map memory, then writes
// the run one cell per cycle through the single write port. A bad run length
// is refused without a read of the map. s_tready is high only while the
// block is idle, so one item is in work at a time.
// The result sits in an output register; while the receiver stalls, the
// block still takes the next item and holds its own result until the
// register is free. Reset empties the region at once: the region length
// acts as a fill count, so no cell at or above it is ever read.
module nearest_fit_cell_allocator
  import nfca_pkg::*;
#(
  parameter int DEPTH   = NFCA_DEPTH,
  parameter int MAX_RUN = NFCA_MAX_RUN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cell_index[7:0], run_length[13:8], zero
  input  logic [0:0]  s_tuser,   // req_type[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // base_index[7:0], status[9:8], used_length[18:10], zero
);

  localparam int IW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = ((LW > INDEX_W) ? LW : INDEX_W) + 1;
  localparam int DW = (IW > INDEX_W) ? IW : INDEX_W;
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [CW-1:0] MAX_RUN_C = CW'(MAX_RUN);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PLACE = 5'b00100,
    S_MARK  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t              state;
  logic [INDEX_W-1:0]  req_near;
  logic [RUN_W-1:0]    req_len;
  logic [LW-1:0]       rl;
  logic [IW-1:0]       addr;
  logic                issuing;
  logic                pend;
  logic [IW-1:0]       pidx;
  logic                rdata;
  logic [RUN_W-1:0]    zrun;
  logic                tail;
  logic                found;
  logic [IW-1:0]       best;
  logic [DW-1:0]       best_dist;
  logic [IW-1:0]       maddr;
  logic [RUN_W-1:0]    mcnt;
  logic [INDEX_W-1:0]  res_base;
  status_t             res_status;

  logic                mem [DEPTH];
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic                mem_wbit;

  logic                in_fire;
  logic [INDEX_W-1:0]  in_near;
  logic [RUN_W-1:0]    in_len;
  logic                near_in_region;
  logic                len_bad;
  logic [RUN_W-1:0]    zrun_next;
  logic                tail_next;
  logic                cand;
  logic [DW-1:0]       pidx_w;
  logic [DW-1:0]       near_w;
  logic [DW-1:0]       gap;
  logic [CW-1:0]       base_c;
  logic [CW-1:0]       end_c;
  logic                res_load;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign in_near  = s_tdata[7:0];
  assign in_len   = s_tdata[13:8];

  assign near_in_region = CW'(in_near) < CW'(rl);
  assign len_bad        = (in_len == '0) || (CW'(in_len) > MAX_RUN_C);

  // Zero-run tracking while the map is read from the top down.
  assign zrun_next = rdata ? '0 : ((zrun == req_len) ? zrun : zrun + 1'b1);
  assign tail_next = tail && !rdata;
  assign cand      = !rdata && (tail_next || (zrun_next == req_len));
  assign pidx_w    = DW'(pidx);
  assign near_w    = DW'(req_near);
  assign gap       = (pidx_w > near_w) ? pidx_w - near_w : near_w - pidx_w;

  assign base_c = found ? CW'(best) : CW'(rl);
  assign end_c  = base_c + CW'(req_len);

  assign res_load = (state == S_RESP) && (!m_tvalid || m_tready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = maddr;
    mem_wbit  = 1'b1;
    if (state == S_MARK) begin
      mem_we = 1'b1;
    end else if (in_fire && (s_tuser[0] == REQ_FREE) && near_in_region) begin
      mem_we    = 1'b1;
      mem_waddr = IW'(in_near);
      mem_wbit  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wbit;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rl       <= '0;
      issuing  <= 1'b0;
      pend     <= 1'b0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            req_near <= in_near;
            req_len  <= in_len;
            res_base <= '0;
            found    <= 1'b0;
            if (s_tuser[0] == REQ_FREE) begin
              res_status <= near_in_region ? ST_DONE : ST_FREE_SKIP;
              state      <= S_RESP;
            end else if (len_bad) begin
              res_status <= ST_NO_ROOM;
              state      <= S_RESP;
            end else if (rl == '0) begin
              state <= S_PLACE;
            end else begin
              addr    <= IW'(rl - 1'b1);
              issuing <= 1'b1;
              pend    <= 1'b0;
              zrun    <= '0;
              tail    <= 1'b1;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pend <= issuing;
          if (issuing) begin
            pidx <= addr;
            if (addr == '0) begin
              issuing <= 1'b0;
            end else begin
              addr <= addr - 1'b1;
            end
          end
          if (pend) begin
            zrun <= zrun_next;
            tail <= tail_next;
            if (cand && (!found || (gap <= best_dist))) begin
              found     <= 1'b1;
              best      <= pidx;
              best_dist <= gap;
            end
          end
          if (!issuing && !pend) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (end_c > DEPTH_C) begin
            res_status <= ST_NO_ROOM;
            res_base   <= '0;
            state      <= S_RESP;
          end else begin
            res_status <= ST_DONE;
            res_base   <= INDEX_W'(base_c);
            maddr      <= IW'(base_c);
            mcnt       <= req_len;
            if (end_c > CW'(rl)) begin
              rl <= LW'(end_c);
            end
            state <= S_MARK;
          end
        end
        S_MARK: begin
          maddr <= maddr + 1'b1;
          mcnt  <= mcnt - 1'b1;
          if (mcnt == RUN_W'(1)) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (res_load) begin
            m_tdata <= {5'b0, LENGTH_W'(rl), res_status, res_base};
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/nfca_checker.sv =====
`include "nearest_fit_cell_allocator_assert.svh"

module nfca_checker
  import nfca_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  logic [LENGTH_W-1:0] last_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_len <= '0;
    end else if (m_tvalid && m_tready) begin
      last_len <= m_tdata[18:10];
    end
  end

  `NFCA_ASSERT_NOW(a_status_code, m_tvalid,
    (m_tdata[9:8] == ST_DONE) || (m_tdata[9:8] == ST_NO_ROOM) ||
    (m_tdata[9:8] == ST_FREE_SKIP), "Result item carries an unknown status.")
  `NFCA_ASSERT_NOW(a_base_zero, m_tvalid && (m_tdata[9:8] != ST_DONE),
    m_tdata[7:0] == 8'd0, "Refused or skipped item reports a nonzero base.")
  `NFCA_ASSERT_NOW(a_length_grows, m_tvalid, m_tdata[18:10] >= last_len,
    "Region length shrank between result items.")
  `NFCA_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready,
    "Block took a second item while one is in work.")

endmodule

bind nearest_fit_cell_allocator nfca_checker u_nfca_checker (.*);
